>>> hw/rtl/rcpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpfa_pkg: shared types and constants of the page frame allocator
// Sizes, operation and status codes, sequencer states and memory port bundles.
// ----------------------------------------------------------------------------
package rcpfa_pkg;

    // Sizing
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int COUNT_BITS = 8;

    localparam int IDX_W     = $clog2(NUM_PAGES);
    localparam int OFFS_W    = $clog2(PAGE_BYTES);
    localparam int ADDR_W    = 27;
    localparam int LIMIT_W   = 28;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(NUM_PAGES - 1);
    localparam logic [ADDR_W:0]       PAGES_C  = (ADDR_W + 1)'(NUM_PAGES);

    localparam logic [LIMIT_W-1:0] LOW_RESET  = LIMIT_W'(0);
    localparam logic [LIMIT_W-1:0] HIGH_RESET = LIMIT_W'(134217728);

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADDREF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEED   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 1'd1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } seq_state_t;

    // Address check result
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } chk_t;

    // Count memory port bundle
    typedef struct packed {
        logic                  re;
        logic [IDX_W-1:0]      raddr;
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [COUNT_BITS-1:0] wdata;
    } cnt_port_t;

    // Next-page memory port bundle
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
    } nxt_port_t;

endpackage

>>> hw/rtl/rcpfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpfa_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with enable; read data registered and held.
// ----------------------------------------------------------------------------
module rcpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/rcpfa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpfa_chk: page address check
// Tests alignment, the managed window and the page range; yields the index.
// ----------------------------------------------------------------------------
module rcpfa_chk
    import rcpfa_pkg::*;
(
    input  logic [ADDR_W-1:0]  addr,
    input  logic [LIMIT_W-1:0] low_limit,
    input  logic [LIMIT_W-1:0] high_limit,
    output chk_t               chk
);

    logic [ADDR_W-1:0]  page_full;
    logic [LIMIT_W-1:0] addr_ext;
    logic               aligned;
    logic               in_window;
    logic               in_range;

    always_comb
    begin
        page_full = addr >> OFFS_W;
        addr_ext  = LIMIT_W'(addr);
        aligned   = (addr[OFFS_W-1:0] == '0);
        in_window = (addr_ext >= low_limit) && (addr_ext < high_limit);
        in_range  = ({1'b0, page_full} < PAGES_C);
        chk.ok    = aligned && in_window && in_range;
        chk.idx   = IDX_W'(page_full);
    end

endmodule

>>> hw/rtl/rcpfa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpfa_seq: allocator sequencer
// Clears the count memory, reads, modifies and writes back per operation,
// keeps the free list head and holds the result register.
// ----------------------------------------------------------------------------
module rcpfa_seq
    import rcpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [CMD_W-1:0]      cmd,
    input  chk_t                  chk,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     page_addr,
    output logic [COUNT_BITS-1:0] ref_count,
    output cnt_port_t             cnt_port,
    input  logic [COUNT_BITS-1:0] cnt_rdata,
    output nxt_port_t             nxt_port,
    input  logic [IDX_W-1:0]      nxt_rdata
);

    seq_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic                  empty_reg, empty_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  bad_reg, bad_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ADDR_W-1:0]     paddr_reg, paddr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                      accept;
    logic                      fire;
    logic [COUNT_BITS-1:0]     cnt_dec;
    logic [COUNT_BITS-1:0]     cnt_inc;
    logic [IDX_W+OFFS_W-1:0]   head_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        bad_reg    <= bad_next;
        status_reg <= status_next;
        paddr_reg  <= paddr_next;
        count_reg  <= count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        bad_next       = bad_reg;
        status_next    = status_reg;
        paddr_next     = paddr_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        accept     = req_valid && (state_reg == S_IDLE);
        fire       = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
        cnt_dec    = cnt_rdata - CNT_ONE;
        cnt_inc    = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + CNT_ONE;
        head_bytes = {head_reg, {OFFS_W{1'b0}}};

        // Read at the accepted page and at the list head
        cnt_port.re    = accept;
        cnt_port.raddr = chk.idx;
        cnt_port.we    = 1'b0;
        cnt_port.waddr = idx_reg;
        cnt_port.wdata = CNT_ZERO;
        nxt_port.re    = accept;
        nxt_port.raddr = head_reg;
        nxt_port.we    = 1'b0;
        nxt_port.waddr = idx_reg;
        nxt_port.wdata = empty_reg ? idx_reg : head_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cnt_port.we    = 1'b1;
                cnt_port.waddr = clr_reg;
                clr_next       = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                    cmd_next   = cmd;
                    idx_next   = chk.idx;
                    bad_next   = !chk.ok;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    paddr_next     = '0;
                    count_next     = CNT_ZERO;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (empty_reg)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            // Pop the head; a self-pointing entry ends the list
                            cnt_port.we    = 1'b1;
                            cnt_port.waddr = head_reg;
                            cnt_port.wdata = CNT_ONE;
                            if (nxt_rdata == head_reg)
                            begin
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                head_next = nxt_rdata;
                            end
                            paddr_next = ADDR_W'(head_bytes);
                            count_next = CNT_ONE;
                        end
                    end
                    else if (bad_reg)
                    begin
                        status_next = ST_BADADDR;
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_FREE:
                            begin
                                if (cnt_rdata == CNT_ZERO)
                                begin
                                    status_next = ST_ZERO;
                                end
                                else
                                begin
                                    cnt_port.we    = 1'b1;
                                    cnt_port.wdata = cnt_dec;
                                    count_next     = cnt_dec;
                                    if (cnt_dec == CNT_ZERO)
                                    begin
                                        nxt_port.we = 1'b1;
                                        head_next   = idx_reg;
                                        empty_next  = 1'b0;
                                        status_next = ST_RELEASED;
                                    end
                                end
                            end
                            CMD_ADDREF:
                            begin
                                cnt_port.we    = 1'b1;
                                cnt_port.wdata = cnt_inc;
                                count_next     = cnt_inc;
                            end
                            CMD_SEED:
                            begin
                                // Count is written as zero and the page is pushed onto the free list
                                cnt_port.we    = 1'b1;
                                cnt_port.wdata = CNT_ZERO;
                                nxt_port.we    = 1'b1;
                                head_next      = idx_reg;
                                empty_next     = 1'b0;
                                status_next    = ST_RELEASED;
                            end
                            default:
                            begin
                                status_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        req_stall = (state_reg != S_IDLE);
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign page_addr = paddr_reg;
    assign ref_count = count_reg;

endmodule

>>> hw/rtl/refcounted_page_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator: page frame allocator with reference counts
// LIFO free list linked through a next-page memory, plus a per-page count
// memory; alloc, free, add-reference and seed operations.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ------------------------------
//  req       in         req_valid / req_stall  cmd, addr
//  rsp       out        rsp_valid / rsp_stall  status, page_addr, ref_count
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Each operation is accepted in S_IDLE, which issues the reads of the
//  count memory and the next-page memory; in S_EXEC the sequencer writes
//  back and loads the result register, held off while a result is stalled.
//  After reset the count memory is cleared one entry per cycle, all NUM_PAGES
//  entries (32768), with req_stall high; cfg writes are taken throughout.
//  A held result stalls only the write-back of the following operation.
//
module refcounted_page_frame_allocator
    import rcpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [ADDR_W-1:0]     addr,
    // Result channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     page_addr,
    output logic [COUNT_BITS-1:0] ref_count,
    // Configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LIMIT_W-1:0]    cfg_data
);

    logic [LIMIT_W-1:0] low_limit_reg, low_limit_next;
    logic [LIMIT_W-1:0] high_limit_reg, high_limit_next;

    chk_t                  chk;
    cnt_port_t             cnt_port;
    nxt_port_t             nxt_port;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [IDX_W-1:0]      nxt_rdata;

    // Configuration registers: always ready, one transfer per cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= LOW_RESET;
            high_limit_reg <= HIGH_RESET;
        end
        else
        begin
            low_limit_reg  <= low_limit_next;
            high_limit_reg <= high_limit_next;
        end
    end

    always_comb
    begin
        low_limit_next  = low_limit_reg;
        high_limit_next = high_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_LIMIT:  low_limit_next  = cfg_data;
                CFG_HIGH_LIMIT: high_limit_next = cfg_data;
                default:        low_limit_next  = low_limit_reg;
            endcase
        end
    end

    // Check the incoming address against the managed window
    rcpfa_chk u_chk (
        .addr       (addr),
        .low_limit  (low_limit_reg),
        .high_limit (high_limit_reg),
        .chk        (chk)
    );

    // Per-page reference counts
    rcpfa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_port.we),
        .waddr (cnt_port.waddr),
        .wdata (cnt_port.wdata),
        .re    (cnt_port.re),
        .raddr (cnt_port.raddr),
        .rdata (cnt_rdata)
    );

    // Free list links; an entry's read data is used only after it was written
    rcpfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_port.we),
        .waddr (nxt_port.waddr),
        .wdata (nxt_port.wdata),
        .re    (nxt_port.re),
        .raddr (nxt_port.raddr),
        .rdata (nxt_rdata)
    );

    // Read-modify-write sequencer with head register and result register
    rcpfa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .chk       (chk),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .page_addr (page_addr),
        .ref_count (ref_count),
        .cnt_port  (cnt_port),
        .cnt_rdata (cnt_rdata),
        .nxt_port  (nxt_port),
        .nxt_rdata (nxt_rdata)
    );

    // One operation in flight: a transfer closes the request side next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while an operation is in flight");

    // Only a successful alloc returns a page address
    a_paddr_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_DONE) |-> (page_addr == '0))
        else $error("page address on a result other than done");

    // Released, empty, bad-address and zero-count results carry count zero
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_RELEASED || status == ST_EMPTY ||
                       status == ST_BADADDR || status == ST_ZERO))
        |-> (ref_count == '0))
        else $error("nonzero count on a result that must report zero");

    // A nonzero page address comes with a count of one
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && page_addr != '0) |-> (ref_count == CNT_ONE))
        else $error("allocated page without a count of one");

endmodule
